>>> hw/rtl/epav_pkg.sv
package epav_pkg;

    // Fixed-point constants
    localparam logic [16:0] ONE_Q16   = 17'h10000;
    localparam logic [16:0] HALF_Q16  = 17'h08000;
    localparam logic [47:0] TWOPI_Q32 = 48'h0006_487E_D511;
    localparam logic [16:0] CPR_MIN   = 17'd2;
    localparam logic [16:0] CPR_MAX   = 17'h10000;

    // Register indexes (byte address = 8 * index)
    localparam logic [2:0] REG_CPR  = 3'd0;
    localparam logic [2:0] REG_DIR  = 3'd1;
    localparam logic [2:0] REG_PPC  = 3'd2;
    localparam logic [2:0] REG_OFF  = 3'd3;
    localparam logic [2:0] REG_OFFF = 3'd4;
    localparam logic [2:0] REG_T    = 3'd5;
    localparam logic [2:0] REG_KP   = 3'd6;
    localparam logic [2:0] REG_KI   = 3'd7;

    // Shared unit operations
    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_MOD,
        ALU_DIVR
    } t_alu_op;

    // Product right shift (rounded)
    typedef enum logic [1:0] {
        SH0,
        SH16,
        SH24,
        SH32
    } t_shift;

    typedef struct packed {
        logic    start;
        t_alu_op op;
        t_shift  sh;
        logic    sat48;
    } t_alu_req;

    typedef enum logic [2:0] {
        A_IDLE,
        A_MUL,
        A_RND,
        A_SAT,
        A_DIV,
        A_FIX
    } t_alu_st;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RSYNC,
        S_WRAP,
        S_CNT,
        S_KP,
        S_KI,
        S_DV,
        S_DREV,
        S_CP,
        S_CR,
        S_PIR,
        S_CI,
        S_SNAP,
        S_OMM,
        S_OMD,
        S_PF,
        S_EX,
        S_EMOD,
        S_EMUL,
        S_EDIV,
        S_MMUL,
        S_MDIV,
        S_DONE
    } t_state;

endpackage

>>> hw/rtl/epav_alu.sv
module epav_alu (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  epav_pkg::t_alu_req   i_req,
    input  logic signed [63:0]   i_a,
    input  logic [47:0]          i_b,
    output logic                 o_done,
    output logic signed [63:0]   o_res
);

    localparam logic [5:0] MUL_LAST = 6'd2;
    localparam logic [5:0] DIV_LAST = 6'd63;

    epav_pkg::t_alu_st r_state, n_state;
    epav_pkg::t_alu_op r_op;
    epav_pkg::t_shift  r_sh;
    logic              r_sat48;
    logic              r_neg;
    logic [63:0]       r_mag;
    logic [47:0]       r_b;
    logic [111:0]      r_acc;
    logic [5:0]        r_cnt;
    logic [33:0]       r_rem;
    logic [32:0]       r_div;
    logic [63:0]       r_quo;
    logic              r_done;
    logic signed [63:0] r_res;

    logic              w_load;
    logic              w_fin;
    logic [63:0]       w_amag;
    logic [63:0]       w_dvd;
    logic [79:0]       w_prod;
    logic [111:0]      w_acc_nx;
    logic [111:0]      w_rnd;
    logic [111:0]      w_shifted;
    logic [111:0]      w_lim;
    logic [63:0]       w_mag_out;
    logic [63:0]       w_mul_res;
    logic [33:0]       w_trial;
    logic              w_ge;
    logic [32:0]       w_modr;
    logic [63:0]       w_div_res;

    // Operand magnitude and rounded dividend
    assign w_amag = i_a[63] ? (64'd0 - i_a) : i_a;
    assign w_dvd  = w_amag + ((i_req.op == epav_pkg::ALU_DIVR) ? {32'd0, i_b[32:1]} : 64'd0);

    // One 64x16 digit per cycle, most significant digit first
    assign w_prod   = r_mag * r_b[47:32];
    assign w_acc_nx = {r_acc[95:0], 16'd0} + {32'd0, w_prod};

    // Round, shift and saturate
    always_comb begin
        case (r_sh)
            epav_pkg::SH16: begin
                w_rnd     = 112'd1 << 15;
                w_shifted = r_acc >> 16;
            end
            epav_pkg::SH24: begin
                w_rnd     = 112'd1 << 23;
                w_shifted = r_acc >> 24;
            end
            epav_pkg::SH32: begin
                w_rnd     = 112'd1 << 31;
                w_shifted = r_acc >> 32;
            end
            default: begin
                w_rnd     = 112'd0;
                w_shifted = r_acc;
            end
        endcase
    end

    assign w_lim     = (r_sat48 ? (112'd1 << 47) : (112'd1 << 62)) - {111'd0, ~r_neg};
    assign w_mag_out = (w_shifted > w_lim) ? w_lim[63:0] : w_shifted[63:0];
    assign w_mul_res = r_neg ? (64'd0 - w_mag_out) : w_mag_out;

    // Restoring division, one quotient bit per cycle
    assign w_trial = {r_rem[32:0], r_quo[63]};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    assign w_modr    = (r_neg && (r_rem[32:0] != 33'd0)) ? (r_div - r_rem[32:0]) : r_rem[32:0];
    assign w_div_res = r_neg ? (64'd0 - r_quo) : r_quo;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            epav_pkg::A_IDLE: begin
                if (i_req.start) begin
                    n_state = (i_req.op == epav_pkg::ALU_MUL) ? epav_pkg::A_MUL : epav_pkg::A_DIV;
                end
            end
            epav_pkg::A_MUL: begin
                if (r_cnt == MUL_LAST) n_state = epav_pkg::A_RND;
            end
            epav_pkg::A_RND: n_state = epav_pkg::A_SAT;
            epav_pkg::A_SAT: n_state = epav_pkg::A_IDLE;
            epav_pkg::A_DIV: begin
                if (r_cnt == DIV_LAST) n_state = epav_pkg::A_FIX;
            end
            epav_pkg::A_FIX: n_state = epav_pkg::A_IDLE;
            default:         n_state = epav_pkg::A_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        w_load = 1'b0;
        w_fin  = 1'b0;
        case (r_state)
            epav_pkg::A_IDLE: w_load = i_req.start;
            epav_pkg::A_SAT:  w_fin  = 1'b1;
            epav_pkg::A_FIX:  w_fin  = 1'b1;
            default: begin
                w_load = 1'b0;
                w_fin  = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= epav_pkg::A_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= 6'd0;
        end else begin
            r_state <= n_state;
            r_done  <= w_fin;
            if (w_load) begin
                r_cnt <= 6'd0;
            end else if (r_state == epav_pkg::A_MUL || r_state == epav_pkg::A_DIV) begin
                r_cnt <= r_cnt + 6'd1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_op    <= i_req.op;
            r_sh    <= i_req.sh;
            r_sat48 <= i_req.sat48;
            r_neg   <= i_a[63];
            r_mag   <= w_amag;
            r_b     <= i_b;
            r_acc   <= 112'd0;
            r_rem   <= 34'd0;
            r_div   <= i_b[32:0];
            r_quo   <= w_dvd;
        end else begin
            case (r_state)
                epav_pkg::A_MUL: begin
                    r_acc <= w_acc_nx;
                    r_b   <= {r_b[31:0], 16'd0};
                end
                epav_pkg::A_RND: r_acc <= r_acc + w_rnd;
                epav_pkg::A_SAT: r_res <= w_mul_res;
                epav_pkg::A_DIV: begin
                    r_rem <= w_ge ? (w_trial - {1'b0, r_div}) : w_trial;
                    r_quo <= {r_quo[62:0], w_ge};
                end
                epav_pkg::A_FIX: begin
                    r_res <= (r_op == epav_pkg::ALU_MOD) ? {31'd0, w_modr} : w_div_res;
                end
                default: r_acc <= r_acc;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

>>> hw/rtl/encoder_pll_angle_velocity_core.sv
// Each tick item runs seven 64-step radix-2 divisions and its multiplies on the
// shared unit; a resync item runs a single modulo division. Throughput: one item
// at a time; the next request is taken once the result is latched in the output
// register. Reset (synchronous, active low) loads the register defaults and
// clears the loop state, phase fraction to one half.
module encoder_pll_angle_velocity_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Input requests
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [15:0]   s_axis_tdata,   // [15:0] raw_count
    input  logic [0:0]    s_axis_tuser,   // [0] op
    // Results
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [103:0]  m_axis_tdata,   // [31:0] mech_velocity, [51:32] elec_angle,
                                          // [99:52] mech_angle, [103:100] zero
    // Configuration
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [5:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);

    epav_pkg::t_state   r_state, n_state;
    epav_pkg::t_alu_req w_req;
    logic signed [63:0] w_a;
    logic [47:0]        w_b;
    logic               w_done;
    logic signed [63:0] w_res;

    // Configuration registers
    logic [16:0] r_cfg_cpr;
    logic [1:0]  r_cfg_dir;
    logic [6:0]  r_cfg_ppc;
    logic [15:0] r_cfg_off;
    logic [15:0] r_cfg_offf;
    logic [31:0] r_cfg_t;
    logic [31:0] r_cfg_kp;
    logic [47:0] r_cfg_ki;

    // Loop state
    logic [15:0]        r_last;
    logic [31:0]        r_shadow;
    logic signed [47:0] r_pe;
    logic [32:0]        r_pir;
    logic signed [47:0] r_vel;
    logic [16:0]        r_pf;

    // Per-item working registers
    logic               r_wait;
    logic               r_op;
    logic [15:0]        r_raw;
    logic [16:0]        r_cpr;
    logic signed [17:0] r_delta;
    logic [16:0]        r_count;
    logic [47:0]        r_kpdt;
    logic [47:0]        r_kidt;
    logic signed [51:0] r_prev;
    logic signed [17:0] r_drev;
    logic signed [63:0] r_t;
    logic signed [31:0] r_omega;
    logic [19:0]        r_eang;
    logic signed [47:0] r_mang;
    logic               r_ovalid;
    logic [103:0]       r_odata;

    logic               w_cfg_we;
    logic [16:0]        w_cpr_eff;
    logic [15:0]        w_half;
    logic [47:0]        w_div_cpr;
    logic [47:0]        w_div_cpr8;
    logic [47:0]        w_div_cpr16;
    logic signed [17:0] w_d0;
    logic signed [17:0] w_halfs;
    logic signed [17:0] w_cprs;
    logic signed [17:0] w_delta;
    logic signed [63:0] w_pe64;
    logic signed [63:0] w_prev64;
    logic signed [63:0] w_vel64;
    logic signed [63:0] w_sh64;
    logic signed [63:0] w_drev64;
    logic signed [63:0] w_dpos;
    logic signed [63:0] w_drev_in;
    logic signed [63:0] w_cdiff;
    logic signed [63:0] w_xe;
    logic signed [63:0] w_xm;
    logic signed [63:0] w_res_dir;
    logic signed [63:0] w_pf_sum;
    logic [47:0]        w_vmag;
    logic               w_pf_mul;
    logic               w_in_acc;
    logic               w_out_free;

    epav_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    function automatic logic signed [47:0] sat48(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_7FFF_FFFF_FFFF;
        lo = -64'sh0000_8000_0000_0000;
        if (x > hi) return hi[47:0];
        if (x < lo) return lo[47:0];
        return x[47:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (x > hi) return hi[31:0];
        if (x < lo) return lo[31:0];
        return x[31:0];
    endfunction

    // Configuration write and read
    assign pready   = 1'b1;
    assign w_cfg_we = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cpr  <= 17'd4096;
            r_cfg_dir  <= 2'd1;
            r_cfg_ppc  <= 7'd7;
            r_cfg_off  <= 16'd0;
            r_cfg_offf <= 16'd0;
            r_cfg_t    <= 32'd214748;
            r_cfg_kp   <= 32'd131072000;
            r_cfg_ki   <= 48'd65536000000;
        end else if (w_cfg_we) begin
            case (paddr[5:3])
                epav_pkg::REG_CPR:  r_cfg_cpr  <= pwdata[16:0];
                epav_pkg::REG_DIR:  r_cfg_dir  <= pwdata[1:0];
                epav_pkg::REG_PPC:  r_cfg_ppc  <= pwdata[6:0];
                epav_pkg::REG_OFF:  r_cfg_off  <= pwdata[15:0];
                epav_pkg::REG_OFFF: r_cfg_offf <= pwdata[15:0];
                epav_pkg::REG_T:    r_cfg_t    <= pwdata[31:0];
                epav_pkg::REG_KP:   r_cfg_kp   <= pwdata[31:0];
                epav_pkg::REG_KI:   r_cfg_ki   <= pwdata[47:0];
                default:            r_cfg_cpr  <= r_cfg_cpr;
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            epav_pkg::REG_CPR:  prdata = {47'd0, r_cfg_cpr};
            epav_pkg::REG_DIR:  prdata = {62'd0, r_cfg_dir};
            epav_pkg::REG_PPC:  prdata = {57'd0, r_cfg_ppc};
            epav_pkg::REG_OFF:  prdata = {48'd0, r_cfg_off};
            epav_pkg::REG_OFFF: prdata = {48'd0, r_cfg_offf};
            epav_pkg::REG_T:    prdata = {32'd0, r_cfg_t};
            epav_pkg::REG_KP:   prdata = {32'd0, r_cfg_kp};
            epav_pkg::REG_KI:   prdata = {16'd0, r_cfg_ki};
            default:            prdata = 64'd0;
        endcase
    end

    // Clamp counts per revolution
    assign w_cpr_eff = (r_cfg_cpr < epav_pkg::CPR_MIN) ? epav_pkg::CPR_MIN :
                       (r_cfg_cpr > epav_pkg::CPR_MAX) ? epav_pkg::CPR_MAX : r_cfg_cpr;

    assign w_half      = r_cpr[16:1];
    assign w_div_cpr   = {31'd0, r_cpr};
    assign w_div_cpr8  = {23'd0, r_cpr, 8'd0};
    assign w_div_cpr16 = {15'd0, r_cpr, 16'd0};

    // Wrap the reading difference into half a revolution
    assign w_d0    = $signed({2'b00, r_raw}) - $signed({2'b00, r_last});
    assign w_halfs = $signed({2'b00, w_half});
    assign w_cprs  = $signed({1'b0, r_cpr});
    assign w_delta = (w_d0 > w_halfs) ? (w_d0 - w_cprs) :
                     (w_d0 < -w_halfs) ? (w_d0 + w_cprs) : w_d0;

    // Sign-extended operands
    assign w_pe64   = {{16{r_pe[47]}}, r_pe};
    assign w_prev64 = {{12{r_prev[51]}}, r_prev};
    assign w_vel64  = {{16{r_vel[47]}}, r_vel};
    assign w_sh64   = {{32{r_shadow[31]}}, r_shadow};
    assign w_drev64 = {{46{r_drev[17]}}, r_drev};

    // Phase detector inputs
    assign w_dpos    = w_sh64 - (w_pe64 >>> 16);
    assign w_drev_in = $signed({47'd0, r_count}) - (w_prev64 >>> 16)
                     + $signed({48'd0, w_half});

    // Angle inputs with the offset removed
    assign w_cdiff = $signed({47'd0, r_count}) - $signed({48'd0, r_cfg_off});
    assign w_xe    = (w_cdiff <<< 16) + $signed({47'd0, r_pf}) - $signed({48'd0, r_cfg_offf});
    assign w_xm    = w_pe64 - $signed({32'd0, r_cfg_off, 16'd0}) - $signed({48'd0, r_cfg_offf});

    assign w_res_dir = r_cfg_dir[1] ? (64'sd0 - w_res) : w_res;
    assign w_pf_sum  = $signed({47'd0, r_pf}) + w_res;
    assign w_vmag    = r_vel[47] ? (48'd0 - r_vel) : r_vel;
    assign w_pf_mul  = (r_vel != 48'sd0) && (r_delta == 18'sd0);

    assign w_in_acc   = s_axis_tvalid & s_axis_tready;
    assign w_out_free = ~r_ovalid | m_axis_tready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            epav_pkg::S_IDLE: begin
                if (w_in_acc) n_state = s_axis_tuser[0] ? epav_pkg::S_RSYNC : epav_pkg::S_WRAP;
            end
            epav_pkg::S_RSYNC: if (w_done) n_state = epav_pkg::S_DONE;
            epav_pkg::S_WRAP:  n_state = epav_pkg::S_CNT;
            epav_pkg::S_CNT:   if (w_done) n_state = epav_pkg::S_KP;
            epav_pkg::S_KP:    if (w_done) n_state = epav_pkg::S_KI;
            epav_pkg::S_KI:    if (w_done) n_state = epav_pkg::S_DV;
            epav_pkg::S_DV:    if (w_done) n_state = epav_pkg::S_DREV;
            epav_pkg::S_DREV:  if (w_done) n_state = epav_pkg::S_CP;
            epav_pkg::S_CP:    if (w_done) n_state = epav_pkg::S_CR;
            epav_pkg::S_CR:    if (w_done) n_state = epav_pkg::S_PIR;
            epav_pkg::S_PIR:   if (w_done) n_state = epav_pkg::S_CI;
            epav_pkg::S_CI:    if (w_done) n_state = epav_pkg::S_SNAP;
            epav_pkg::S_SNAP:  n_state = epav_pkg::S_OMM;
            epav_pkg::S_OMM:   if (w_done) n_state = epav_pkg::S_OMD;
            epav_pkg::S_OMD:   if (w_done) n_state = epav_pkg::S_PF;
            epav_pkg::S_PF:    if (!w_pf_mul || w_done) n_state = epav_pkg::S_EX;
            epav_pkg::S_EX:    if (w_done) n_state = epav_pkg::S_EMOD;
            epav_pkg::S_EMOD:  if (w_done) n_state = epav_pkg::S_EMUL;
            epav_pkg::S_EMUL:  if (w_done) n_state = epav_pkg::S_EDIV;
            epav_pkg::S_EDIV:  if (w_done) n_state = epav_pkg::S_MMUL;
            epav_pkg::S_MMUL:  if (w_done) n_state = epav_pkg::S_MDIV;
            epav_pkg::S_MDIV:  if (w_done) n_state = epav_pkg::S_DONE;
            epav_pkg::S_DONE:  if (w_out_free) n_state = epav_pkg::S_IDLE;
            default:           n_state = epav_pkg::S_IDLE;
        endcase
    end

    // Shared unit requests per state
    always_comb begin
        w_req.start = 1'b0;
        w_req.op    = epav_pkg::ALU_MUL;
        w_req.sh    = epav_pkg::SH0;
        w_req.sat48 = 1'b0;
        w_a         = 64'sd0;
        w_b         = 48'd0;
        s_axis_tready = (r_state == epav_pkg::S_IDLE);
        case (r_state)
            epav_pkg::S_RSYNC: begin
                w_req.start = ~r_wait;
                w_req.op    = epav_pkg::ALU_MOD;
                w_a         = $signed({48'd0, r_raw});
                w_b         = w_div_cpr;
            end
            epav_pkg::S_CNT: begin
                w_req.start = ~r_wait;
                w_req.op    = epav_pkg::ALU_MOD;
                w_a         = w_sh64;
                w_b         = w_div_cpr;
            end
            epav_pkg::S_KP: begin
                w_req.start = ~r_wait;
                w_req.sh    = epav_pkg::SH16;
                w_a         = $signed({32'd0, r_cfg_kp});
                w_b         = {16'd0, r_cfg_t};
            end
            epav_pkg::S_KI: begin
                w_req.start = ~r_wait;
                w_req.sh    = epav_pkg::SH32;
                w_a         = $signed({16'd0, r_cfg_ki});
                w_b         = {16'd0, r_cfg_t};
            end
            epav_pkg::S_DV: begin
                w_req.start = ~r_wait;
                w_req.sh    = epav_pkg::SH32;
                w_req.sat48 = 1'b1;
                w_a         = w_vel64;
                w_b         = {16'd0, r_cfg_t};
            end
            epav_pkg::S_DREV: begin
                w_req.start = ~r_wait;
                w_req.op    = epav_pkg::ALU_MOD;
                w_a         = w_drev_in;
                w_b         = w_div_cpr;
            end
            epav_pkg::S_CP: begin
                w_req.start = ~r_wait;
                w_req.sh    = epav_pkg::SH16;
                w_req.sat48 = 1'b1;
                w_a         = w_dpos;
                w_b         = r_kpdt;
            end
            epav_pkg::S_CR: begin
                w_req.start = ~r_wait;
                w_req.sh    = epav_pkg::SH16;
                w_req.sat48 = 1'b1;
                w_a         = w_drev64;
                w_b         = r_kpdt;
            end
            epav_pkg::S_PIR: begin
                w_req.start = ~r_wait;
                w_req.op    = epav_pkg::ALU_MOD;
                w_a         = w_prev64;
                w_b         = w_div_cpr16;
            end
            epav_pkg::S_CI: begin
                w_req.start = ~r_wait;
                w_a         = w_drev64;
                w_b         = r_kidt;
            end
            epav_pkg::S_OMM, epav_pkg::S_EMUL: begin
                w_req.start = ~r_wait;
                w_req.sh    = epav_pkg::SH24;
                w_a         = (r_state == epav_pkg::S_OMM) ? w_vel64 : r_t;
                w_b         = epav_pkg::TWOPI_Q32;
            end
            epav_pkg::S_MMUL: begin
                w_req.start = ~r_wait;
                w_req.sh    = epav_pkg::SH24;
                w_a         = w_xm;
                w_b         = epav_pkg::TWOPI_Q32;
            end
            epav_pkg::S_OMD, epav_pkg::S_EDIV, epav_pkg::S_MDIV: begin
                w_req.start = ~r_wait;
                w_req.op    = epav_pkg::ALU_DIVR;
                w_a         = r_t;
                w_b         = w_div_cpr8;
            end
            epav_pkg::S_PF: begin
                w_req.start = ~r_wait & w_pf_mul;
                w_req.sh    = epav_pkg::SH32;
                w_req.sat48 = 1'b1;
                w_a         = w_vel64;
                w_b         = {16'd0, r_cfg_t};
            end
            epav_pkg::S_EX: begin
                w_req.start = ~r_wait;
                w_a         = w_xe;
                w_b         = {41'd0, r_cfg_ppc};
            end
            epav_pkg::S_EMOD: begin
                w_req.start = ~r_wait;
                w_req.op    = epav_pkg::ALU_MOD;
                w_a         = r_t;
                w_b         = w_div_cpr16;
            end
            default: begin
                w_req.start = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= epav_pkg::S_IDLE;
            r_wait   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_req.start) begin
                r_wait <= 1'b1;
            end else if (w_done) begin
                r_wait <= 1'b0;
            end
            if (r_state == epav_pkg::S_DONE && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= 16'd0;
            r_shadow <= 32'd0;
            r_pe     <= 48'sd0;
            r_pir    <= 33'd0;
            r_vel    <= 48'sd0;
            r_pf     <= epav_pkg::HALF_Q16;
            r_cpr    <= 17'd4096;
        end else begin
            if (w_in_acc) r_cpr <= w_cpr_eff;
            case (r_state)
                epav_pkg::S_RSYNC: begin
                    if (w_done) begin
                        r_last   <= r_raw;
                        r_shadow <= {15'd0, w_res[16:0]};
                        r_pe     <= $signed({15'd0, w_res[16:0], 16'd0});
                        r_pir    <= {w_res[16:0], 16'd0};
                        r_vel    <= 48'sd0;
                        r_pf     <= epav_pkg::HALF_Q16;
                    end
                end
                epav_pkg::S_WRAP: begin
                    r_shadow <= r_shadow + {{14{w_delta[17]}}, w_delta};
                    r_last   <= r_raw;
                end
                epav_pkg::S_DV:  if (w_done) r_pe  <= sat48(w_pe64 + w_res);
                epav_pkg::S_CP:  if (w_done) r_pe  <= sat48(w_pe64 + w_res);
                epav_pkg::S_PIR: if (w_done) r_pir <= w_res[32:0];
                epav_pkg::S_CI:  if (w_done) r_vel <= sat48(w_vel64 + w_res);
                epav_pkg::S_SNAP: begin
                    if ({w_vmag, 1'b0} < {1'b0, r_kidt}) r_vel <= 48'sd0;
                end
                epav_pkg::S_PF: begin
                    // Snap phase on a count edge, hold centered when stopped, else advance by velocity times period
                    if (!w_pf_mul) begin
                        if (r_vel == 48'sd0)         r_pf <= epav_pkg::HALF_Q16;
                        else if (r_delta > 18'sd0)   r_pf <= 17'd0;
                        else                         r_pf <= epav_pkg::ONE_Q16;
                    end else if (w_done) begin
                        if (w_pf_sum > $signed({47'd0, epav_pkg::ONE_Q16})) begin
                            r_pf <= epav_pkg::ONE_Q16;
                        end else if (w_pf_sum < 64'sd0) begin
                            r_pf <= 17'd0;
                        end else begin
                            r_pf <= w_pf_sum[16:0];
                        end
                    end
                end
                default: r_last <= r_last;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_raw <= s_axis_tdata;
            r_op  <= s_axis_tuser[0];
        end
        case (r_state)
            epav_pkg::S_RSYNC: begin
                if (w_done) begin
                    r_omega <= 32'sd0;
                    r_eang  <= 20'd0;
                    r_mang  <= 48'sd0;
                end
            end
            epav_pkg::S_WRAP: r_delta <= w_delta;
            epav_pkg::S_CNT:  if (w_done) r_count <= w_res[16:0];
            epav_pkg::S_KP:   if (w_done) r_kpdt  <= w_res[47:0];
            epav_pkg::S_KI:   if (w_done) r_kidt  <= w_res[47:0];
            epav_pkg::S_DV:   if (w_done) r_prev  <= $signed({19'd0, r_pir}) + w_res[51:0];
            epav_pkg::S_DREV: if (w_done) r_drev  <= $signed({1'b0, w_res[16:0]})
                                                   - $signed({2'b00, w_half});
            epav_pkg::S_CR:   if (w_done) r_prev  <= r_prev + w_res[51:0];
            epav_pkg::S_OMM, epav_pkg::S_EX, epav_pkg::S_EMOD,
            epav_pkg::S_EMUL, epav_pkg::S_MMUL: begin
                if (w_done) r_t <= w_res;
            end
            epav_pkg::S_OMD:  if (w_done) r_omega <= sat32(w_res_dir);
            epav_pkg::S_EDIV: if (w_done) r_eang  <= w_res_dir[19:0];
            epav_pkg::S_MDIV: if (w_done) r_mang  <= sat48(w_res_dir);
            epav_pkg::S_DONE: begin
                if (w_out_free) r_odata <= {4'd0, r_mang, r_eang, r_omega};
            end
            default: r_t <= r_t;
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // Checks
    a_pf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pf <= epav_pkg::ONE_Q16)
        else $error("phase fraction above one");

    a_pir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == epav_pkg::S_IDLE) |-> (r_pir < {r_cpr, 16'd0}))
        else $error("position in revolution out of range");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == epav_pkg::S_KP) |-> (r_count < r_cpr))
        else $error("count not below counts per revolution");

    a_done_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> r_wait)
        else $error("unit result with no request pending");

    a_tick_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == epav_pkg::S_WRAP) |-> !r_op)
        else $error("resync request on the tick path");

endmodule

>>> test/tb.sv
module tb;

    localparam longint LIM47      = 64'sd1 <<< 47;
    localparam int     LAT_CYCLES = 700;
    localparam int     CYCLE_LIMIT = 8000000;
    localparam int     ITEMS_PER_PHASE = 300;
    localparam logic   OP_TICK   = 1'b0;
    localparam logic   OP_RESYNC = 1'b1;

    typedef struct {
        logic signed [31:0] vel;
        logic signed [19:0] elec;
        logic signed [47:0] mech;
    } t_angle_result;

    typedef struct {
        logic          op;
        logic [15:0]   raw;
        bit            known;
        t_angle_result res;
    } t_stim_row;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [15:0]   s_axis_tdata;   // [15:0] raw_count
    logic [0:0]    s_axis_tuser;   // [0] op
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [103:0]  m_axis_tdata;   // [31:0] mech_velocity, [51:32] elec_angle,
                                   // [99:52] mech_angle, [103:100] zero
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [5:0]    paddr;
    logic [63:0]   pwdata;
    logic [63:0]   prdata;
    logic          pready;

    encoder_pll_angle_velocity_core i_dut (.*);

    // Register copies
    logic [16:0] cfg_cpr;
    logic [1:0]  cfg_dir;
    logic [6:0]  cfg_ppc;
    logic [15:0] cfg_off;
    logic [15:0] cfg_offf;
    logic [31:0] cfg_period;
    logic [31:0] cfg_kp;
    logic [47:0] cfg_ki;

    // Loop state copies
    logic [15:0] last_rd;
    logic [31:0] shadow_cnt;
    longint      pos_est, pos_rev, vel_est, phase_frac;

    t_angle_result expected_angles[$];
    int  mismatches = 0;
    int  cycle_cnt = 0;
    bit  quiet;
    int  track_pos;

    t_stim_row directed_rows [0:15] = '{
        '{OP_RESYNC, 16'd0,     1'b1, '{32'sd0, 20'sd0, 48'sd0}},
        '{OP_TICK,   16'd0,     1'b0, '{32'sd0, 20'sd0, 48'sd0}},
        '{OP_TICK,   16'd1,     1'b0, '{32'sd0, 20'sd0, 48'sd0}},
        '{OP_TICK,   16'd3,     1'b0, '{32'sd0, 20'sd0, 48'sd0}},
        '{OP_TICK,   16'd4095,  1'b0, '{32'sd0, 20'sd0, 48'sd0}},
        '{OP_TICK,   16'd4095,  1'b0, '{32'sd0, 20'sd0, 48'sd0}},
        '{OP_TICK,   16'd2047,  1'b0, '{32'sd0, 20'sd0, 48'sd0}},
        '{OP_TICK,   16'd0,     1'b0, '{32'sd0, 20'sd0, 48'sd0}},
        '{OP_TICK,   16'd2048,  1'b0, '{32'sd0, 20'sd0, 48'sd0}},
        '{OP_TICK,   16'd2049,  1'b0, '{32'sd0, 20'sd0, 48'sd0}},
        '{OP_TICK,   16'd65535, 1'b0, '{32'sd0, 20'sd0, 48'sd0}},
        '{OP_RESYNC, 16'd65535, 1'b1, '{32'sd0, 20'sd0, 48'sd0}},
        '{OP_TICK,   16'd65535, 1'b0, '{32'sd0, 20'sd0, 48'sd0}},
        '{OP_TICK,   16'd4095,  1'b0, '{32'sd0, 20'sd0, 48'sd0}},
        '{OP_RESYNC, 16'd100,   1'b1, '{32'sd0, 20'sd0, 48'sd0}},
        '{OP_TICK,   16'd101,   1'b0, '{32'sd0, 20'sd0, 48'sd0}}
    };

    // Rounded, saturated (a*b) >> sh
    function automatic longint mul_shift(longint a, logic [63:0] b, int sh, int width);
        logic [127:0] p;
        logic [63:0]  mag;
        logic [63:0]  lim;
        bit           neg;
        neg = (a < 0);
        mag = neg ? (64'd0 - 64'(a)) : 64'(a);
        p = {64'd0, mag} * {64'd0, b};
        if (sh > 0) p = (p + (128'd1 << (sh - 1))) >> sh;
        lim = (64'd1 << (width - 1)) - (neg ? 64'd0 : 64'd1);
        if (p > {64'd0, lim}) p = {64'd0, lim};
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic longint div_round(longint n, logic [63:0] d);
        logic [63:0] mag;
        logic [63:0] q;
        mag = (n < 0) ? (64'd0 - 64'(n)) : 64'(n);
        q = (mag + d / 2) / d;
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp(longint x, longint lim);
        if (x > lim - 1) return lim - 1;
        if (x < -lim) return -lim;
        return x;
    endfunction

    function automatic longint wrap_mod(longint a, longint m);
        longint r;
        r = a % m;
        return (r < 0) ? r + m : r;
    endfunction

    function automatic longint counts_to_rad(longint x, longint cpr);
        return div_round(mul_shift(x, 64'(epav_pkg::TWOPI_Q32), 24, 63), 64'(cpr) << 8);
    endfunction

    function automatic longint active_cpr();
        if (cfg_cpr < epav_pkg::CPR_MIN) return 2;
        if (cfg_cpr > epav_pkg::CPR_MAX) return 65536;
        return longint'(cfg_cpr);
    endfunction

    task automatic reset_tracker();
        cfg_cpr = 17'd4096;  cfg_dir = 2'd1;  cfg_ppc = 7'd7;
        cfg_off = 16'd0;     cfg_offf = 16'd0;
        cfg_period = 32'd214748;  cfg_kp = 32'd131072000;  cfg_ki = 48'd65536000000;
        last_rd = 16'd0;  shadow_cnt = 32'd0;
        pos_est = 0;  pos_rev = 0;  vel_est = 0;  phase_frac = 32768;
    endtask

    // Advance the loop state by one request and compute its angles
    task automatic track_angles(input logic op, input logic [15:0] raw,
                                output t_angle_result r);
        longint cpr, delta, shadow, count, kp_dt, ki_dt, dv, prev, dpos, drev;
        longint vmag, omega, x, e, eang, mang, dsign;
        cpr = active_cpr();
        dsign = cfg_dir[1] ? -1 : 1;
        if (op == OP_RESYNC) begin
            count = longint'(raw) % cpr;
            last_rd = raw;
            shadow_cnt = 32'(count);
            pos_est = count * 65536;
            pos_rev = count * 65536;
            vel_est = 0;
            phase_frac = 32768;
            r = '{32'sd0, 20'sd0, 48'sd0};
            return;
        end
        delta = longint'(raw) - longint'(last_rd);
        if (delta > cpr / 2) delta -= cpr;
        else if (delta < -(cpr / 2)) delta += cpr;
        shadow_cnt = shadow_cnt + 32'(delta);
        last_rd = raw;
        shadow = longint'($signed(shadow_cnt));
        count = wrap_mod(shadow, cpr);

        kp_dt = mul_shift(longint'(cfg_kp), 64'(cfg_period), 16, 63);
        ki_dt = mul_shift(longint'(cfg_ki), 64'(cfg_period), 32, 63);

        // predict
        dv = mul_shift(vel_est, 64'(cfg_period), 32, 48);
        pos_est = clamp(pos_est + dv, LIM47);
        prev = pos_rev + dv;

        // phase errors
        dpos = shadow - (pos_est >>> 16);
        drev = wrap_mod(count - (prev >>> 16) + cpr / 2, cpr) - cpr / 2;

        // correct
        pos_est = clamp(pos_est + mul_shift(dpos, 64'(kp_dt), 16, 48), LIM47);
        prev += mul_shift(drev, 64'(kp_dt), 16, 48);
        pos_rev = wrap_mod(prev, cpr * 65536);
        vel_est = clamp(vel_est + mul_shift(drev, 64'(ki_dt), 0, 63), LIM47);
        vmag = (vel_est < 0) ? -vel_est : vel_est;
        if (2 * vmag < ki_dt) vel_est = 0;

        omega = clamp(counts_to_rad(vel_est, cpr) * dsign, 64'sd1 <<< 31);

        // sub-count interpolation
        if (vel_est == 0) phase_frac = 32768;
        else if (delta > 0) phase_frac = 0;
        else if (delta < 0) phase_frac = 65536;
        else begin
            phase_frac += mul_shift(vel_est, 64'(cfg_period), 32, 48);
            if (phase_frac > 65536) phase_frac = 65536;
            else if (phase_frac < 0) phase_frac = 0;
        end

        x = (count - longint'(cfg_off)) * 65536 + phase_frac - longint'(cfg_offf);
        e = wrap_mod(x * longint'(cfg_ppc), cpr * 65536);
        eang = counts_to_rad(e, cpr) * dsign;
        x = pos_est - longint'(cfg_off) * 65536 - longint'(cfg_offf);
        mang = clamp(counts_to_rad(x, cpr) * dsign, LIM47);

        r.vel  = omega[31:0];
        r.elec = eang[19:0];
        r.mech = mang[47:0];
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: random stall, check each accepted result
    always @(posedge i_clk) begin
        t_angle_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_angles.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", m_axis_tdata);
            end else begin
                want = expected_angles.pop_front();
                if (m_axis_tdata[31:0] !== want.vel || m_axis_tdata[51:32] !== want.elec ||
                    m_axis_tdata[99:52] !== want.mech) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch vel %h/%h elec %h/%h mech %h/%h",
                                 want.vel, m_axis_tdata[31:0], want.elec,
                                 m_axis_tdata[51:32], want.mech, m_axis_tdata[99:52]);
                end
            end
        end
        m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 30);
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(posedge i_clk);
        psel <= 1'b1;  penable <= 1'b0;  pwrite <= 1'b1;
        paddr <= {idx, 3'b000};  pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;  penable <= 1'b0;
        case (idx)
            epav_pkg::REG_CPR:  cfg_cpr    = value[16:0];
            epav_pkg::REG_DIR:  cfg_dir    = value[1:0];
            epav_pkg::REG_PPC:  cfg_ppc    = value[6:0];
            epav_pkg::REG_OFF:  cfg_off    = value[15:0];
            epav_pkg::REG_OFFF: cfg_offf   = value[15:0];
            epav_pkg::REG_T:    cfg_period = value[31:0];
            epav_pkg::REG_KP:   cfg_kp     = value[31:0];
            default:            cfg_ki     = value[47:0];
        endcase
    endtask

    // Apply one setting: 0 defaults, 1 low extremes, 2 high extremes, else random
    task automatic load_setting(input int kind);
        logic [63:0] ki_val;
        case (kind)
            0: begin
                write_reg(epav_pkg::REG_CPR, 64'd4096);
                write_reg(epav_pkg::REG_DIR, 64'd1);
                write_reg(epav_pkg::REG_PPC, 64'd7);
                write_reg(epav_pkg::REG_OFF, 64'd0);
                write_reg(epav_pkg::REG_OFFF, 64'd0);
                write_reg(epav_pkg::REG_T, 64'd214748);
                write_reg(epav_pkg::REG_KP, 64'd131072000);
                write_reg(epav_pkg::REG_KI, 64'd65536000000);
            end
            1: begin
                write_reg(epav_pkg::REG_CPR, 64'd0);
                write_reg(epav_pkg::REG_DIR, 64'd0);
                write_reg(epav_pkg::REG_PPC, 64'd1);
                write_reg(epav_pkg::REG_OFF, 64'd0);
                write_reg(epav_pkg::REG_OFFF, 64'd0);
                write_reg(epav_pkg::REG_T, 64'd1);
                write_reg(epav_pkg::REG_KP, 64'd0);
                write_reg(epav_pkg::REG_KI, 64'd0);
            end
            2: begin
                write_reg(epav_pkg::REG_CPR, 64'h1FFFF);
                write_reg(epav_pkg::REG_DIR, 64'd3);
                write_reg(epav_pkg::REG_PPC, 64'h7F);
                write_reg(epav_pkg::REG_OFF, 64'hFFFF);
                write_reg(epav_pkg::REG_OFFF, 64'hFFFF);
                write_reg(epav_pkg::REG_T, 64'hFFFF_FFFF);
                write_reg(epav_pkg::REG_KP, 64'hFFFF_FFFF);
                write_reg(epav_pkg::REG_KI, 64'hFFFF_FFFF_FFFF);
            end
            default: begin
                // half the time loop-like gains, else raw random words
                write_reg(epav_pkg::REG_CPR,
                          ($urandom_range(3) == 0) ? 64'($urandom_range(131071))
                                                   : 64'($urandom_range(65536, 2)));
                write_reg(epav_pkg::REG_DIR, 64'($urandom_range(3)));
                write_reg(epav_pkg::REG_PPC, 64'($urandom_range(127)));
                write_reg(epav_pkg::REG_OFF, 64'($urandom_range(65535)));
                write_reg(epav_pkg::REG_OFFF, 64'($urandom_range(65535)));
                if ($urandom_range(1)) begin
                    write_reg(epav_pkg::REG_T, 64'($urandom_range(2000000, 40000)));
                    write_reg(epav_pkg::REG_KP, 64'($urandom_range(400000000, 1000000)));
                    ki_val = 64'($urandom_range(400000, 1000)) * 64'd65536;
                end else begin
                    write_reg(epav_pkg::REG_T, 64'($urandom));
                    write_reg(epav_pkg::REG_KP, 64'($urandom));
                    ki_val = {$urandom, $urandom};
                end
                write_reg(epav_pkg::REG_KI, ki_val);
            end
        endcase
    endtask

    // Drive one request, at times with a random gap before it unless quiet
    task automatic send_reading(input logic op, input logic [15:0] raw,
                                input bit known, input t_angle_result typed);
        t_angle_result r;
        if (!quiet && $urandom_range(99) < 30) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < 30) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        track_angles(op, raw, r);
        expected_angles.push_back(known ? typed : r);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_angles.size() != 0) @(posedge i_clk);
        repeat (LAT_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_angle_result none;
        logic [15:0] raw;
        logic        op;
        int          pick;
        longint      cpr;
        none = '{32'sd0, 20'sd0, 48'sd0};
        quiet = 1'b0;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;  s_axis_tdata <= '0;  s_axis_tuser <= '0;
        psel <= 1'b0;  penable <= 1'b0;  pwrite <= 1'b0;  paddr <= '0;  pwdata <= '0;
        reset_tracker();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows under the reset defaults
        foreach (directed_rows[k])
            send_reading(directed_rows[k].op, directed_rows[k].raw,
                         directed_rows[k].known, directed_rows[k].res);

        // Random phases, each behind a new setting
        for (int phase = 0; phase < 6; phase++) begin
            drain();
            load_setting((phase == 0) ? 3 : (phase == 1) ? 1 : (phase == 2) ? 2 :
                         (phase == 5) ? 0 : 4);
            quiet = (phase == 3);
            cpr = active_cpr();
            track_pos = $urandom_range(int'(cpr) - 1);
            send_reading(OP_RESYNC, 16'(track_pos), 1'b1, none);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(99);
                op = OP_TICK;
                if (pick < 5) begin
                    op = OP_RESYNC;
                    raw = 16'($urandom_range(65535));
                end else if (pick < 10) begin
                    raw = 16'($urandom_range(65535));
                end else begin
                    // random steps of up to six counts either way, at times a half-revolution jump
                    track_pos = int'(wrap_mod(longint'(track_pos) +
                                     longint'($urandom_range(12)) - 6, cpr));
                    if (pick < 14)
                        track_pos = int'(wrap_mod(longint'(track_pos) + cpr / 2, cpr));
                    raw = 16'(track_pos);
                end
                if (op == OP_RESYNC && raw < cpr) track_pos = int'(raw);
                send_reading(op, raw, op == OP_RESYNC, none);
            end
        end

        drain();
        if (mismatches == 0 && expected_angles.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/epav_pkg.sv
hw/rtl/epav_alu.sv
hw/rtl/encoder_pll_angle_velocity_core.sv
test/tb.sv
